@@ hdl/assembler_source_lexer_assert.svh @@
// Assertion macros shared by the lexer checker.
`ifndef ASSEMBLER_SOURCE_LEXER_ASSERT_SVH
`define ASSEMBLER_SOURCE_LEXER_ASSERT_SVH

// Implication checked in the same cycle.
`define ASL_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lexer assertion failed");

// Implication checked in the next cycle.
`define ASL_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lexer assertion failed");

`endif

@@ hdl/asl_pkg.sv @@
// Shared types, result codes and helpers of the assembler source lexer.
package asl_pkg;

	localparam int TOKEN_MAX_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] K_EOL = 4'd0;
	localparam logic [3:0] K_EOF = 4'd1;
	localparam logic [3:0] K_PUNCT = 4'd2;
	localparam logic [3:0] K_IDENT_CHAR = 4'd3;
	localparam logic [3:0] K_IDENT_END = 4'd4;
	localparam logic [3:0] K_STR_CHAR = 4'd5;
	localparam logic [3:0] K_STR_END = 4'd6;
	localparam logic [3:0] K_INT = 4'd7;
	localparam logic [3:0] K_REAL = 4'd8;
	localparam logic [3:0] K_ERROR = 4'd9;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_BAD_CHAR = 3'd1;
	localparam logic [2:0] E_TOO_LONG = 3'd2;
	localparam logic [2:0] E_BAD_ESC = 3'd3;
	localparam logic [2:0] E_UNTERM = 3'd4;
	localparam logic [2:0] E_OPEN_COMMENT = 3'd5;
	localparam logic [2:0] E_BAD_NUMBER = 3'd6;
	localparam logic [2:0] E_ESC_RANGE = 3'd7;

	typedef struct packed {
		logic [3:0] kind;
		logic [31:0] value;
		logic [2:0] error_code;
		logic is_real;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t r0;
		res_t r1;
		logic [31:0] dec;
		logic [31:0] frac;
		logic [3:0] ndig;
	} bundle_t;

	function automatic bundle_t push(bundle_t b, logic [3:0] k, logic [31:0] v,
			logic [2:0] e);
		res_t r;
		r.kind = k;
		r.value = v;
		r.error_code = e;
		r.is_real = 1'b0;
		if (b.count == 2'd0) begin
			b.r0 = r;
		end else begin
			b.r1 = r;
		end
		b.count = b.count + 2'd1;
		return b;
	endfunction

	function automatic logic [29:0] pow10(logic [3:0] n);
		logic [29:0] p;
		case (n)
			4'd0: p = 30'd1;
			4'd1: p = 30'd10;
			4'd2: p = 30'd100;
			4'd3: p = 30'd1000;
			4'd4: p = 30'd10000;
			4'd5: p = 30'd100000;
			4'd6: p = 30'd1000000;
			4'd7: p = 30'd10000000;
			4'd8: p = 30'd100000000;
			4'd9: p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

@@ hdl/asl_if.sv @@
// Valid/ready channel interfaces for source bytes and lexer results.
interface asl_in_if;
	logic valid;
	logic ready;
	logic [7:0] ch;
	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface asl_out_if;
	logic valid;
	logic ready;
	logic [3:0] kind;
	logic signed [31:0] value;
	logic [2:0] error_code;
	logic last;
	modport source(output valid, output kind, output value, output error_code,
		output last, input ready);
	modport sink(input valid, input kind, input value, input error_code,
		input last, output ready);
endinterface

@@ hdl/asl_front.sv @@
// Lexer front: scanner state machine, one source byte per cycle into result bundles while the queue is not full.
module asl_front #(
	parameter int TOKEN_MAX = asl_pkg::TOKEN_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] ch,
	output logic in_ready,
	input logic full,
	output logic push_en,
	output asl_pkg::bundle_t push_data
);

	typedef enum logic [3:0] {
		M_NORMAL, M_EOLRUN, M_LINECOM, M_SLASH, M_BLOCK, M_BLOCKSTAR,
		M_IDENT, M_STRING, M_STR_ESC, M_STR_HEX, M_STR_OCT,
		M_CHAR, M_CHAR_ESC, M_NUMBER, M_NUMBER_B, M_ERROR
	} mode_t;

	localparam logic [6:0] TMAX = 7'(TOKEN_MAX);
	localparam logic [5:0] F_HEX_BAD = 6'd1;
	localparam logic [5:0] F_DEC_BAD = 6'd2;
	localparam logic [5:0] F_OCT_BAD = 6'd4;
	localparam logic [5:0] F_BIN_BAD = 6'd8;
	localparam logic [5:0] F_PREFIX = 6'd16;
	localparam logic [5:0] F_DOT = 6'd32;

	mode_t mode_q, nm;
	logic [6:0] tlen_q, n_tlen;
	logic [31:0] hex_q, dec_q, oct_q, bin_q, frac_q, cpack_q;
	logic [31:0] n_hex, n_dec, n_oct, n_bin, n_frac, n_cpack;
	logic [5:0] flags_q, n_flags;
	logic [3:0] fd_q, n_fd;
	logic [8:0] esc_q, n_esc;
	asl_pkg::bundle_t b;
	logic go_norm, go_str, go_num, acc;
	logic [4:0] d;
	logic [8:0] se;
	logic [12:0] t13;
	logic [11:0] t12;
	logic ok;
	logic [31:0] v;
	logic [3:0] k;

	function automatic logic [4:0] hex_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
		return 5'd16;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		logic r;
		case (c)
			"*", "+", "-", "~", ",", "[", "]", ":", "#", "!", "|", "&", "=", "<",
			">", "(", ")", "{", "}", "\\": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] simple_esc(logic [7:0] c);
		logic [8:0] r;
		case (c)
			"'": r = {1'b1, 8'h27};
			"\"": r = {1'b1, 8'h22};
			"?": r = {1'b1, 8'h3F};
			"\\": r = {1'b1, 8'h5C};
			"a": r = {1'b1, 8'd7};
			"b": r = {1'b1, 8'd8};
			"f": r = {1'b1, 8'd12};
			"n": r = {1'b1, 8'd10};
			"r": r = {1'b1, 8'd13};
			"t": r = {1'b1, 8'd9};
			"v": r = {1'b1, 8'd11};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat(logic [35:0] x);
		return (x[35:32] != 4'd0) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	assign in_ready = !full;
	assign acc = in_valid && !full;
	assign push_en = acc && (b.count != 2'd0);
	assign push_data = b;

	always_comb begin
		b = '0;
		nm = mode_q;
		n_tlen = tlen_q;
		n_hex = hex_q;
		n_dec = dec_q;
		n_oct = oct_q;
		n_bin = bin_q;
		n_frac = frac_q;
		n_cpack = cpack_q;
		n_flags = flags_q;
		n_fd = fd_q;
		n_esc = esc_q;
		go_norm = 1'b0;
		go_str = 1'b0;
		go_num = 1'b0;
		d = hex_of(ch);
		se = simple_esc(ch);
		t13 = '0;
		t12 = '0;
		ok = 1'b0;
		v = '0;
		k = asl_pkg::K_INT;
		unique case (mode_q)
			M_ERROR: ;
			M_EOLRUN: if (ch != 8'h0A && ch != 8'h0D) go_norm = 1'b1;
			M_LINECOM: if (ch == 8'h0A || ch == 8'h0D || ch == 8'h00) go_norm = 1'b1;
			M_SLASH: begin
				if (ch == "/") nm = M_LINECOM;
				else if (ch == "*") nm = M_BLOCK;
				else begin
					b = asl_pkg::push(b, asl_pkg::K_PUNCT, 32'h2F, asl_pkg::E_NONE);
					go_norm = 1'b1;
				end
			end
			M_BLOCK, M_BLOCKSTAR: begin
				if (ch == 8'h00) begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_OPEN_COMMENT);
					nm = M_ERROR;
				end else if (ch == "*") nm = M_BLOCKSTAR;
				else if (mode_q == M_BLOCKSTAR && ch == "/") nm = M_NORMAL;
				else nm = M_BLOCK;
			end
			M_IDENT: begin
				if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
					if (tlen_q >= TMAX) begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_TOO_LONG);
						nm = M_ERROR;
					end else begin
						n_tlen = tlen_q + 7'd1;
						b = asl_pkg::push(b, asl_pkg::K_IDENT_CHAR, 32'(ch), asl_pkg::E_NONE);
					end
				end else begin
					b = asl_pkg::push(b, asl_pkg::K_IDENT_END, 32'd0, asl_pkg::E_NONE);
					go_norm = 1'b1;
				end
			end
			M_STRING: go_str = 1'b1;
			M_STR_ESC: begin
				if (se[8]) begin
					b = asl_pkg::push(b, asl_pkg::K_STR_CHAR, 32'(se[7:0]), asl_pkg::E_NONE);
					nm = M_STRING;
				end else if (ch == "x") begin
					n_esc = '0;
					n_fd = 4'd0;
					nm = M_STR_HEX;
				end else if (ch >= "0" && ch <= "7") begin
					n_esc = 9'(ch - "0");
					n_fd = 4'd1;
					nm = M_STR_OCT;
				end else begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_ESC);
					nm = M_ERROR;
				end
			end
			M_STR_HEX: begin
				t13 = {esc_q, 4'h0} + 13'(d);
				if (d != 5'd16) begin
					if (t13 > 13'd255) begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_ESC_RANGE);
						nm = M_ERROR;
					end else begin
						n_esc = t13[8:0];
						n_fd = 4'd1;
					end
				end else if (fd_q == 4'd0) begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_ESC);
					nm = M_ERROR;
				end else begin
					b = asl_pkg::push(b, asl_pkg::K_STR_CHAR, 32'(esc_q), asl_pkg::E_NONE);
					nm = M_STRING;
					go_str = 1'b1;
				end
			end
			M_STR_OCT: begin
				if (ch >= "0" && ch <= "7") begin
					t12 = {esc_q, 3'b0} + 12'(d);
					n_esc = t12[8:0];
					n_fd = fd_q + 4'd1;
					if (n_fd >= 4'd3) begin
						if (n_esc > 9'd255) begin
							b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_ESC_RANGE);
							nm = M_ERROR;
						end else begin
							b = asl_pkg::push(b, asl_pkg::K_STR_CHAR, 32'(n_esc),
								asl_pkg::E_NONE);
							nm = M_STRING;
						end
					end
				end else begin
					b = asl_pkg::push(b, asl_pkg::K_STR_CHAR, 32'(esc_q), asl_pkg::E_NONE);
					nm = M_STRING;
					go_str = 1'b1;
				end
			end
			M_CHAR: begin
				if (ch == "'") begin
					b = asl_pkg::push(b, asl_pkg::K_INT, cpack_q, asl_pkg::E_NONE);
					nm = M_NORMAL;
				end else if (ch < 8'h20 || ch > 8'h7E) begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_UNTERM);
					nm = M_ERROR;
				end else if (tlen_q >= 7'd4) begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_TOO_LONG);
					nm = M_ERROR;
				end else begin
					n_tlen = tlen_q + 7'd1;
					if (ch == "\\") nm = M_CHAR_ESC;
					else n_cpack = {cpack_q[23:0], ch};
				end
			end
			M_CHAR_ESC: begin
				if (se[8]) begin
					n_cpack = {cpack_q[23:0], se[7:0]};
					nm = M_CHAR;
				end else begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_ESC);
					nm = M_ERROR;
				end
			end
			M_NUMBER, M_NUMBER_B: begin
				if (d != 5'd16 || ch == "x" || ch == ".") begin
					if (mode_q == M_NUMBER_B) n_flags = flags_q | F_BIN_BAD;
					go_num = 1'b1;
				end else if (ch == "h") begin
					if ((flags_q & (F_DOT | F_HEX_BAD)) == 6'd0 &&
							!((flags_q & F_PREFIX) != 6'd0 && tlen_q < 7'd3)) begin
						b = asl_pkg::push(b, asl_pkg::K_INT, hex_q, asl_pkg::E_NONE);
						nm = M_NORMAL;
					end else begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_NUMBER);
						nm = M_ERROR;
					end
				end else if (ch == "q") begin
					if ((flags_q & (F_DOT | F_OCT_BAD | F_PREFIX)) == 6'd0) begin
						b = asl_pkg::push(b, asl_pkg::K_INT, oct_q, asl_pkg::E_NONE);
						nm = M_NORMAL;
					end else begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_NUMBER);
						nm = M_ERROR;
					end
				end else if (is_alpha(ch)) begin
					b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_NUMBER);
					nm = M_ERROR;
				end else begin
					if ((flags_q & F_PREFIX) != 6'd0) begin
						ok = (flags_q & F_HEX_BAD) == 6'd0 && tlen_q > 7'd2;
						v = hex_q;
					end else if (mode_q == M_NUMBER_B) begin
						ok = (flags_q & (F_BIN_BAD | F_DOT)) == 6'd0;
						v = bin_q;
					end else if ((flags_q & F_DOT) != 6'd0) begin
						ok = (flags_q & F_DEC_BAD) == 6'd0 && tlen_q > 7'd1;
						v = dec_q;
						k = asl_pkg::K_REAL;
					end else if (fd_q == 4'd1) begin
						ok = (flags_q & F_OCT_BAD) == 6'd0;
						v = oct_q;
					end else begin
						ok = (flags_q & F_DEC_BAD) == 6'd0;
						v = dec_q;
					end
					if (!ok) begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_NUMBER);
						nm = M_ERROR;
					end else begin
						b = asl_pkg::push(b, k, v, asl_pkg::E_NONE);
						if (k == asl_pkg::K_REAL) begin
							b.r0.is_real = 1'b1;
							b.dec = dec_q;
							b.frac = frac_q;
							b.ndig = (fd_q > 4'd9) ? 4'd9 : fd_q;
						end
						go_norm = 1'b1;
					end
				end
			end
			default: go_norm = 1'b1;
		endcase

		if (go_str) begin
			if (ch == "\"") begin
				b = asl_pkg::push(b, asl_pkg::K_STR_END, 32'd0, asl_pkg::E_NONE);
				nm = M_NORMAL;
			end else if (ch < 8'h20 || ch > 8'h7E) begin
				b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_UNTERM);
				nm = M_ERROR;
			end else if (n_tlen >= TMAX) begin
				b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_TOO_LONG);
				nm = M_ERROR;
			end else begin
				n_tlen = n_tlen + 7'd1;
				if (ch == "\\") nm = M_STR_ESC;
				else b = asl_pkg::push(b, asl_pkg::K_STR_CHAR, 32'(ch), asl_pkg::E_NONE);
			end
		end

		if (go_norm) begin
			nm = M_NORMAL;
			case (ch)
				8'h00: b = asl_pkg::push(b, asl_pkg::K_EOF, 32'd0, asl_pkg::E_NONE);
				8'h0A, 8'h0D: begin
					b = asl_pkg::push(b, asl_pkg::K_EOL, 32'd0, asl_pkg::E_NONE);
					nm = M_EOLRUN;
				end
				";": nm = M_LINECOM;
				"/": nm = M_SLASH;
				8'h20, 8'h09: ;
				"'": begin
					nm = M_CHAR;
					n_tlen = '0;
					n_cpack = '0;
				end
				"\"": begin
					nm = M_STRING;
					n_tlen = '0;
				end
				default: begin
					if (is_punct(ch)) begin
						b = asl_pkg::push(b, asl_pkg::K_PUNCT, 32'(ch), asl_pkg::E_NONE);
					end else if (is_alpha(ch) || ch == "_") begin
						nm = M_IDENT;
						n_tlen = 7'd1;
						b = asl_pkg::push(b, asl_pkg::K_IDENT_CHAR, 32'(ch), asl_pkg::E_NONE);
					end else if (is_digit(ch) || ch == ".") begin
						n_hex = '0;
						n_dec = '0;
						n_oct = '0;
						n_bin = '0;
						n_flags = '0;
						n_frac = '0;
						n_fd = (ch == "0") ? 4'd1 : 4'd0;
						n_tlen = '0;
						go_num = 1'b1;
					end else begin
						b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_BAD_CHAR);
						nm = M_ERROR;
					end
				end
			endcase
		end

		if (go_num) begin
			if (n_tlen >= TMAX) begin
				b = asl_pkg::push(b, asl_pkg::K_ERROR, 32'(ch), asl_pkg::E_TOO_LONG);
				nm = M_ERROR;
			end else begin
				n_tlen = n_tlen + 7'd1;
				nm = M_NUMBER;
				if (ch == ".") begin
					if ((n_flags & F_DOT) != 6'd0) n_flags = n_flags | F_DEC_BAD;
					else n_fd = 4'd0;
					n_flags = n_flags | F_DOT | F_HEX_BAD | F_OCT_BAD | F_BIN_BAD;
				end else if (ch == "x") begin
					if (n_tlen == 7'd2 && (n_flags & F_DOT) == 6'd0 && n_fd == 4'd1)
						n_flags = n_flags | F_PREFIX | F_DEC_BAD | F_OCT_BAD | F_BIN_BAD;
					else
						n_flags = n_flags | F_HEX_BAD | F_DEC_BAD | F_OCT_BAD | F_BIN_BAD;
				end else begin
					n_hex = sat({n_hex, 4'h0} + 36'(d));
					if ((n_flags & F_DOT) != 6'd0) begin
						if (d < 5'd10) begin
							if (n_fd < 4'd9) begin
								n_frac = {n_frac[28:0], 3'b0} + {n_frac[30:0], 1'b0} + 32'(d);
								n_fd = n_fd + 4'd1;
							end
						end else begin
							n_flags = n_flags | F_DEC_BAD;
						end
					end else begin
						if (d < 5'd10)
							n_dec = sat({1'b0, n_dec, 3'b0} + {3'b0, n_dec, 1'b0} + 36'(d));
						else
							n_flags = n_flags | F_DEC_BAD;
						if (d < 5'd8) n_oct = sat({1'b0, n_oct, 3'b0} + 36'(d));
						else n_flags = n_flags | F_OCT_BAD;
						if (ch != "b") begin
							if (d < 5'd2) n_bin = sat({3'b0, n_bin, 1'b0} + 36'(d));
							else n_flags = n_flags | F_BIN_BAD;
						end
					end
					if (ch == "b") nm = M_NUMBER_B;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			tlen_q <= '0;
			hex_q <= '0;
			dec_q <= '0;
			oct_q <= '0;
			bin_q <= '0;
			flags_q <= '0;
			frac_q <= '0;
			fd_q <= '0;
			cpack_q <= '0;
			esc_q <= '0;
		end else if (acc) begin
			mode_q <= nm;
			tlen_q <= n_tlen;
			hex_q <= n_hex;
			dec_q <= n_dec;
			oct_q <= n_oct;
			bin_q <= n_bin;
			flags_q <= n_flags;
			frac_q <= n_frac;
			fd_q <= n_fd;
			cpack_q <= n_cpack;
			esc_q <= n_esc;
		end
	end

endmodule

@@ hdl/asl_fifo.sv @@
// Short bundle queue between the lexer front and back.
module asl_fifo (
	input logic clk,
	input logic arst_n,
	input logic push_en,
	input asl_pkg::bundle_t push_data,
	output logic full,
	input logic pop_en,
	output logic empty,
	output asl_pkg::bundle_t head
);

	localparam int AW = $clog2(asl_pkg::QUEUE_DEPTH);

	asl_pkg::bundle_t mem_q [asl_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(asl_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_en) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_en) wr_q <= wr_q + AW'(1);
			if (pop_en) rd_q <= rd_q + AW'(1);
			if (push_en && !pop_en) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop_en && !push_en) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

@@ hdl/asl_back.sv @@
// Lexer back: unpacks result bundles, converts reals, drives the output register.
module asl_back #(
	parameter int FRAC_BITS = asl_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input asl_pkg::bundle_t head,
	output logic pop_en,
	asl_out_if.source out
);

	localparam int QW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 31;
	localparam int TW = FRAC_BITS + 33;
	localparam int CW = $clog2(QW + 1);

	typedef enum logic {B_RUN, B_DIV} bstate_t;

	bstate_t state_q;
	logic slot_q, done_q;
	logic [DW-1:0] rem_q, dsr_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	asl_pkg::res_t cur;
	logic last_slot, need_div, avail, load;
	logic [29:0] p;
	logic [TW-1:0] total;
	logic [31:0] rval;

	assign cur = slot_q ? head.r1 : head.r0;
	assign last_slot = slot_q || head.count == 2'd1;
	assign need_div = cur.is_real && !done_q;
	assign avail = !empty && state_q == B_RUN && !need_div;
	assign load = avail && (!out.valid || out.ready);
	assign pop_en = load && last_slot;
	assign p = asl_pkg::pow10(head.ndig);
	assign total = {1'b0, head.dec, FRAC_BITS'(0)} + TW'(quo_q);
	assign rval = (total > TW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : total[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
			slot_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
			quo_q <= '0;
			out.valid <= 1'b0;
			out.kind <= '0;
			out.value <= '0;
			out.error_code <= '0;
			out.last <= 1'b0;
		end else begin
			unique case (state_q)
				B_RUN: begin
					if (!empty && need_div) begin
						rem_q <= DW'({head.frac[29:0], FRAC_BITS'(0)}) + DW'(p >> 1);
						dsr_q <= DW'({p, FRAC_BITS'(0)});
						quo_q <= '0;
						cnt_q <= CW'(QW);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (rem_q >= dsr_q) begin
						rem_q <= rem_q - dsr_q;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					dsr_q <= dsr_q >> 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						done_q <= 1'b1;
						state_q <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
			if (load) begin
				out.valid <= 1'b1;
				out.kind <= cur.kind;
				out.value <= cur.is_real ? rval : cur.value;
				out.error_code <= cur.error_code;
				out.last <= last_slot;
				if (last_slot) begin
					slot_q <= 1'b0;
					done_q <= 1'b0;
				end else begin
					slot_q <= 1'b1;
				end
			end else if (out.ready) begin
				out.valid <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/assembler_source_lexer.sv @@
// Top level of the assembler source lexer.
// Usage:
//   in  : one source byte per transfer (ch); byte 0 ends the input and yields eof.
//   out : result transfers (kind, value, error_code, last); last marks the final
//         result caused by one source byte.
// Throughput: one source byte per cycle while the result queue has room.
//   A byte yields zero to two results; they leave at one per cycle unless held.
// Path: each result is written to the queue, then to the output register; a real
//   number first passes through the bit-serial fraction divider of the back end
//   before it leaves.
// Reset: clears the scanner to the between-tokens mode, empties the queue and
//   drops out.valid; any latched error is cleared.
// Stall: when out.ready is low the result holds in the output register; bytes
//   keep transferring until the four-entry queue fills, then in.ready drops.
// After an error result, later bytes transfer but yield nothing until reset.
module assembler_source_lexer #(
	parameter int TOKEN_MAX = asl_pkg::TOKEN_MAX_DEF,
	parameter int FRAC_BITS = asl_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	asl_in_if.sink in,
	asl_out_if.source out
);

	logic full, empty, push_en, pop_en;
	asl_pkg::bundle_t push_data, head;

	asl_front #(.TOKEN_MAX(TOKEN_MAX)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in.valid),
		.ch(in.ch),
		.in_ready(in.ready),
		.full(full),
		.push_en(push_en),
		.push_data(push_data)
	);

	asl_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_en(push_en),
		.push_data(push_data),
		.full(full),
		.pop_en(pop_en),
		.empty(empty),
		.head(head)
	);

	asl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop_en(pop_en),
		.out(out)
	);

endmodule

@@ hdl/asl_checker.sv @@
// Port checker for the assembler source lexer, bound to the top level.
`include "assembler_source_lexer_assert.svh"

module asl_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] kind,
	input logic [2:0] error_code,
	input logic last
);

	`ASL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind))
	`ASL_ASSERT_IMPLY(a_kind_range, clk, arst_n, out_valid, kind <= asl_pkg::K_ERROR)
	`ASL_ASSERT_IMPLY(a_code_clear, clk, arst_n, out_valid && kind != asl_pkg::K_ERROR, error_code == asl_pkg::E_NONE)
	`ASL_ASSERT_IMPLY(a_error_last, clk, arst_n, out_valid && kind == asl_pkg::K_ERROR, last && error_code != asl_pkg::E_NONE)

endmodule

bind assembler_source_lexer asl_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.kind(out.kind),
	.error_code(out.error_code),
	.last(out.last)
);

@@ test/assembler_source_lexer_tb.sv @@
// Self-checking testbench of the assembler source lexer: byte stream in, results checked.
module assembler_source_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOKEN_MAX = asl_pkg::TOKEN_MAX_DEF;
	localparam int FRAC_BITS = asl_pkg::FRAC_BITS_DEF;
	localparam int ESC_MAX = 255;
	localparam int PACK_BYTES = 4;
	localparam int FRAC_KEEP = 9;
	localparam logic [5:0] F_HEX_BAD = 6'd1;
	localparam logic [5:0] F_DEC_BAD = 6'd2;
	localparam logic [5:0] F_OCT_BAD = 6'd4;
	localparam logic [5:0] F_BIN_BAD = 6'd8;
	localparam logic [5:0] F_PREFIX = 6'd16;
	localparam logic [5:0] F_DOT = 6'd32;

	typedef enum logic [3:0] {
		LM_NORMAL, LM_EOLRUN, LM_LINECOM, LM_SLASH, LM_BLOCK, LM_BLOCKSTAR,
		LM_IDENT, LM_STRING, LM_STR_ESC, LM_STR_HEX, LM_STR_OCT,
		LM_CHAR, LM_CHAR_ESC, LM_NUMBER, LM_NUMBER_B, LM_ERROR
	} lex_mode_t;

	typedef struct {
		lex_mode_t mode;
		int unsigned tlen;
		logic [31:0] hexv, decv, octv, binv;
		logic [5:0] flags;
		logic [31:0] fracv;
		int unsigned fdig;
		logic [31:0] pack;
		int unsigned escv;
		bit err;
	} lex_state_t;

	typedef struct {
		logic [3:0] kind;
		logic [31:0] value;
		logic [2:0] code;
		logic last;
	} token_t;

	logic clk;
	logic arst_n;
	asl_in_if in_ch();
	asl_out_if res();

	assembler_source_lexer uut (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(res));

	lex_state_t s;
	lex_state_t gen_st;
	lex_state_t chk_st;
	token_t emitted[$];
	token_t expected_tokens[$];
	byte unsigned source_bytes[$];
	byte unsigned frag[$];
	int n_expected = 0;
	int n_pending = 0;
	int sent = 0;
	int fails = 0;
	bit gen_done = 0;

	function automatic logic [31:0] acc(logic [31:0] a, int unsigned base, int unsigned d);
		logic [63:0] t;
		t = 64'(a) * 64'(base) + 64'(d);
		return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	function automatic int unsigned hex_of(byte unsigned c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	function automatic bit is_alpha(byte unsigned c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_csym(byte unsigned c);
		return is_alpha(c) || c == "_" || (c >= "0" && c <= "9");
	endfunction

	function automatic bit is_print(byte unsigned c);
		return c >= 8'h20 && c <= 8'h7E;
	endfunction

	function automatic bit is_punct(byte unsigned c);
		case (c)
			"*", "+", "-", "~", ",", "[", "]", ":", "#", "!", "|", "&", "=", "<",
			">", "(", ")", "{", "}", "\\": return 1;
			default: return 0;
		endcase
	endfunction

	function automatic int simple_escape(byte unsigned c);
		case (c)
			"'", "\"", "?", "\\": return c;
			"a": return 7;
			"b": return 8;
			"f": return 12;
			"n": return 10;
			"r": return 13;
			"t": return 9;
			"v": return 11;
			default: return -1;
		endcase
	endfunction

	function void emit(logic [3:0] k, logic [31:0] v, logic [2:0] e);
		token_t t;
		t.kind = k;
		t.value = v;
		t.code = e;
		t.last = 0;
		if (emitted.size() < 3) emitted.push_back(t);
	endfunction

	function void raise(logic [2:0] e, byte unsigned c);
		emit(asl_pkg::K_ERROR, 32'(c), e);
		s.mode = LM_ERROR;
		s.err = 1;
	endfunction

	function void number_byte(byte unsigned c);
		int unsigned d;
		if (s.tlen >= TOKEN_MAX) begin
			raise(asl_pkg::E_TOO_LONG, c);
			return;
		end
		s.tlen++;
		s.mode = LM_NUMBER;
		if (c == ".") begin
			if (s.flags & F_DOT) s.flags |= F_DEC_BAD;
			else s.fdig = 0;
			s.flags |= F_DOT | F_HEX_BAD | F_OCT_BAD | F_BIN_BAD;
			return;
		end
		if (c == "x") begin
			if (s.tlen == 2 && !(s.flags & F_DOT) && s.fdig == 1)
				s.flags |= F_PREFIX | F_DEC_BAD | F_OCT_BAD | F_BIN_BAD;
			else
				s.flags |= F_HEX_BAD | F_DEC_BAD | F_OCT_BAD | F_BIN_BAD;
			return;
		end
		d = hex_of(c);
		s.hexv = acc(s.hexv, 16, d);
		if (s.flags & F_DOT) begin
			if (d < 10) begin
				if (s.fdig < FRAC_KEEP) begin
					s.fracv = s.fracv * 32'd10 + 32'(d);
					s.fdig++;
				end
			end else begin
				s.flags |= F_DEC_BAD;
			end
		end else begin
			if (d < 10) s.decv = acc(s.decv, 10, d);
			else s.flags |= F_DEC_BAD;
			if (d < 8) s.octv = acc(s.octv, 8, d);
			else s.flags |= F_OCT_BAD;
			if (c != "b") begin
				if (d < 2) s.binv = acc(s.binv, 2, d);
				else s.flags |= F_BIN_BAD;
			end
		end
		if (c == "b") s.mode = LM_NUMBER_B;
	endfunction

	function automatic logic [31:0] fixed_point_of();
		logic [63:0] p;
		logic [63:0] fr;
		logic [63:0] total;
		int unsigned n;
		n = (s.fdig > FRAC_KEEP) ? FRAC_KEEP : s.fdig;
		p = 1;
		repeat (n) p = p * 10;
		fr = ((64'(s.fracv) << FRAC_BITS) + p / 2) / p;
		total = (64'(s.decv) << FRAC_BITS) + fr;
		return (total > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : total[31:0];
	endfunction

	function void normal_byte(byte unsigned c);
		s.mode = LM_NORMAL;
		case (c)
			8'h00: begin
				emit(asl_pkg::K_EOF, 32'd0, asl_pkg::E_NONE);
				return;
			end
			8'h0A, 8'h0D: begin
				emit(asl_pkg::K_EOL, 32'd0, asl_pkg::E_NONE);
				s.mode = LM_EOLRUN;
				return;
			end
			";": begin
				s.mode = LM_LINECOM;
				return;
			end
			"/": begin
				s.mode = LM_SLASH;
				return;
			end
			" ", 8'h09: return;
			"'": begin
				s.mode = LM_CHAR;
				s.tlen = 0;
				s.pack = 0;
				return;
			end
			"\"": begin
				s.mode = LM_STRING;
				s.tlen = 0;
				return;
			end
			default: ;
		endcase
		if (is_punct(c)) begin
			emit(asl_pkg::K_PUNCT, 32'(c), asl_pkg::E_NONE);
		end else if (is_alpha(c) || c == "_") begin
			s.mode = LM_IDENT;
			s.tlen = 1;
			emit(asl_pkg::K_IDENT_CHAR, 32'(c), asl_pkg::E_NONE);
		end else if ((c >= "0" && c <= "9") || c == ".") begin
			s.hexv = 0;
			s.decv = 0;
			s.octv = 0;
			s.binv = 0;
			s.flags = 0;
			s.fracv = 0;
			s.fdig = (c == "0") ? 1 : 0;
			s.tlen = 0;
			number_byte(c);
		end else begin
			raise(asl_pkg::E_BAD_CHAR, c);
		end
	endfunction

	function void number_end(byte unsigned c);
		logic [5:0] fl;
		bit after_b;
		bit ok;
		logic [3:0] k;
		logic [31:0] v;
		fl = s.flags;
		after_b = s.mode == LM_NUMBER_B;
		k = asl_pkg::K_INT;
		if (c == "h") begin
			if (!(fl & (F_DOT | F_HEX_BAD)) && !((fl & F_PREFIX) && s.tlen < 3)) begin
				emit(asl_pkg::K_INT, s.hexv, asl_pkg::E_NONE);
				s.mode = LM_NORMAL;
			end else raise(asl_pkg::E_BAD_NUMBER, c);
			return;
		end
		if (c == "q") begin
			if (!(fl & (F_DOT | F_OCT_BAD | F_PREFIX))) begin
				emit(asl_pkg::K_INT, s.octv, asl_pkg::E_NONE);
				s.mode = LM_NORMAL;
			end else raise(asl_pkg::E_BAD_NUMBER, c);
			return;
		end
		if (is_alpha(c)) begin
			raise(asl_pkg::E_BAD_NUMBER, c);
			return;
		end
		if (fl & F_PREFIX) begin
			ok = !(fl & F_HEX_BAD) && s.tlen > 2;
			v = s.hexv;
		end else if (after_b) begin
			ok = !(fl & (F_BIN_BAD | F_DOT));
			v = s.binv;
		end else if (fl & F_DOT) begin
			ok = !(fl & F_DEC_BAD) && s.tlen > 1;
			v = fixed_point_of();
			k = asl_pkg::K_REAL;
		end else if (s.fdig == 1) begin
			ok = !(fl & F_OCT_BAD);
			v = s.octv;
		end else begin
			ok = !(fl & F_DEC_BAD);
			v = s.decv;
		end
		if (!ok) begin
			raise(asl_pkg::E_BAD_NUMBER, c);
			return;
		end
		emit(k, v, asl_pkg::E_NONE);
		normal_byte(c);
	endfunction

	function void string_in(byte unsigned c);
		if (c == "\"") begin
			emit(asl_pkg::K_STR_END, 32'd0, asl_pkg::E_NONE);
			s.mode = LM_NORMAL;
		end else if (!is_print(c)) raise(asl_pkg::E_UNTERM, c);
		else if (s.tlen >= TOKEN_MAX) raise(asl_pkg::E_TOO_LONG, c);
		else begin
			s.tlen++;
			if (c == "\\") s.mode = LM_STR_ESC;
			else emit(asl_pkg::K_STR_CHAR, 32'(c), asl_pkg::E_NONE);
		end
	endfunction

	function void lex_byte(byte unsigned c);
		int e;
		int unsigned d;
		emitted.delete();
		case (s.mode)
			LM_ERROR: ;
			LM_EOLRUN: if (c != 8'h0A && c != 8'h0D) normal_byte(c);
			LM_LINECOM: if (c == 8'h0A || c == 8'h0D || c == 8'h00) normal_byte(c);
			LM_SLASH: begin
				if (c == "/") s.mode = LM_LINECOM;
				else if (c == "*") s.mode = LM_BLOCK;
				else begin
					emit(asl_pkg::K_PUNCT, 32'h2F, asl_pkg::E_NONE);
					normal_byte(c);
				end
			end
			LM_BLOCK: begin
				if (c == 8'h00) raise(asl_pkg::E_OPEN_COMMENT, c);
				else if (c == "*") s.mode = LM_BLOCKSTAR;
			end
			LM_BLOCKSTAR: begin
				if (c == 8'h00) raise(asl_pkg::E_OPEN_COMMENT, c);
				else if (c == "/") s.mode = LM_NORMAL;
				else if (c != "*") s.mode = LM_BLOCK;
			end
			LM_IDENT: begin
				if (is_csym(c)) begin
					if (s.tlen >= TOKEN_MAX) raise(asl_pkg::E_TOO_LONG, c);
					else begin
						s.tlen++;
						emit(asl_pkg::K_IDENT_CHAR, 32'(c), asl_pkg::E_NONE);
					end
				end else begin
					emit(asl_pkg::K_IDENT_END, 32'd0, asl_pkg::E_NONE);
					normal_byte(c);
				end
			end
			LM_STRING: string_in(c);
			LM_STR_ESC: begin
				e = simple_escape(c);
				if (e >= 0) begin
					emit(asl_pkg::K_STR_CHAR, 32'(e), asl_pkg::E_NONE);
					s.mode = LM_STRING;
				end else if (c == "x") begin
					s.escv = 0;
					s.fdig = 0;
					s.mode = LM_STR_HEX;
				end else if (c >= "0" && c <= "7") begin
					s.escv = c - "0";
					s.fdig = 1;
					s.mode = LM_STR_OCT;
				end else raise(asl_pkg::E_BAD_ESC, c);
			end
			LM_STR_HEX: begin
				d = hex_of(c);
				if (d < 16) begin
					if (s.escv * 16 + d > ESC_MAX) raise(asl_pkg::E_ESC_RANGE, c);
					else begin
						s.escv = s.escv * 16 + d;
						s.fdig = 1;
					end
				end else if (s.fdig == 0) raise(asl_pkg::E_BAD_ESC, c);
				else begin
					emit(asl_pkg::K_STR_CHAR, 32'(s.escv), asl_pkg::E_NONE);
					s.mode = LM_STRING;
					string_in(c);
				end
			end
			LM_STR_OCT: begin
				if (c >= "0" && c <= "7") begin
					s.escv = (s.escv * 8 + (c - "0")) & 511;
					s.fdig++;
					if (s.fdig >= 3) begin
						if (s.escv > ESC_MAX) raise(asl_pkg::E_ESC_RANGE, c);
						else begin
							emit(asl_pkg::K_STR_CHAR, 32'(s.escv), asl_pkg::E_NONE);
							s.mode = LM_STRING;
						end
					end
				end else begin
					emit(asl_pkg::K_STR_CHAR, 32'(s.escv), asl_pkg::E_NONE);
					s.mode = LM_STRING;
					string_in(c);
				end
			end
			LM_CHAR: begin
				if (c == "'") begin
					emit(asl_pkg::K_INT, s.pack, asl_pkg::E_NONE);
					s.mode = LM_NORMAL;
				end else if (!is_print(c)) raise(asl_pkg::E_UNTERM, c);
				else if (s.tlen >= PACK_BYTES) raise(asl_pkg::E_TOO_LONG, c);
				else begin
					s.tlen++;
					if (c == "\\") s.mode = LM_CHAR_ESC;
					else s.pack = (s.pack << 8) | 32'(c);
				end
			end
			LM_CHAR_ESC: begin
				e = simple_escape(c);
				if (e >= 0) begin
					s.pack = (s.pack << 8) | 32'(e);
					s.mode = LM_CHAR;
				end else raise(asl_pkg::E_BAD_ESC, c);
			end
			LM_NUMBER, LM_NUMBER_B: begin
				if (hex_of(c) < 16 || c == "x" || c == ".") begin
					if (s.mode == LM_NUMBER_B) s.flags |= F_BIN_BAD;
					number_byte(c);
				end else number_end(c);
			end
			default: normal_byte(c);
		endcase
		if (emitted.size() > 0) emitted[emitted.size() - 1].last = 1;
	endfunction

	function void put(string str);
		foreach (str[i]) frag.push_back(str[i]);
	endfunction

	function void commit(bit allow_err);
		s = gen_st;
		foreach (frag[i]) lex_byte(frag[i]);
		if (!s.err || allow_err) begin
			gen_st = s;
			foreach (frag[i]) source_bytes.push_back(frag[i]);
		end
		frag.delete();
	endfunction

	function void put_sep();
		case ($urandom_range(5))
			0: put(" ");
			1: frag.push_back(8'h09);
			2: frag.push_back(8'h0A);
			3: frag.push_back(8'h0D);
			4: put(",");
			default: put(" ");
		endcase
	endfunction

	function void random_frag();
		int n;
		byte unsigned b;
		string esc[$];
		esc = '{"\\n", "\\t", "\\\\", "\\\"", "\\'", "\\?", "\\a", "\\b", "\\f", "\\r",
			"\\v", "\\x7", "\\xff", "\\x41", "\\0", "\\101", "\\377", "\\12"};
		case ($urandom_range(16))
			0, 1: begin
				n = ($urandom_range(15) == 0) ? TOKEN_MAX : int'($urandom_range(1, 8));
				frag.push_back(8'($urandom_range(1) ? "_" : "a" + $urandom_range(25)));
				repeat (n - 1) begin
					b = 8'($urandom_range(62));
					frag.push_back(8'(b < 26 ? "a" + b : b < 52 ? "A" + b - 26 :
						b < 62 ? "0" + b - 52 : "_"));
				end
				put_sep();
			end
			2: begin
				put($sformatf("%0d", $urandom_range(3) == 0 ? $urandom : $urandom_range(999)));
				if ($urandom_range(7) == 0) put("99");
				put_sep();
			end
			3: begin
				put($sformatf("0%0h%s", $urandom, $urandom_range(1) ? "h" : "H"));
				if ($urandom_range(1)) put("h");
				put_sep();
			end
			4: begin
				put($sformatf("0x%0h", $urandom_range(3) == 0 ? $urandom : $urandom_range(255)));
				put_sep();
			end
			5: begin
				put($sformatf("%0oq", $urandom_range(1) ? $urandom : $urandom_range(63)));
				put_sep();
			end
			6: begin
				put($sformatf("0%0o", $urandom_range(4095)));
				put_sep();
			end
			7: begin
				put($sformatf("%0bb", $urandom_range(1) ? $urandom : $urandom_range(15)));
				put_sep();
			end
			8: begin
				put($sformatf("%0d.%0d", $urandom_range(3) == 0 ? $urandom_range(70000) :
					$urandom_range(99), $urandom_range(3) == 0 ? $urandom : $urandom_range(999)));
				put_sep();
			end
			9, 10: begin
				put("\"");
				repeat ($urandom_range(0, 10)) begin
					if ($urandom_range(3) == 0) put(esc[$urandom_range(esc.size() - 1)]);
					else begin
						b = 8'($urandom_range(8'h20, 8'h7E));
						if (b == "\"" || b == "\\") b = "z";
						frag.push_back(b);
					end
				end
				put("\"");
			end
			11: begin
				put("'");
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(3) == 0) put("\\n");
					else frag.push_back(8'($urandom_range(8'h28, 8'h7E)));
				end
				put("'");
			end
			12: begin
				put($urandom_range(1) ? ";" : "//");
				repeat ($urandom_range(0, 8)) frag.push_back(8'($urandom_range(8'h0E, 8'hFF)));
				frag.push_back(8'h0A);
			end
			13: begin
				put("/*");
				repeat ($urandom_range(0, 8)) frag.push_back(8'($urandom_range(1, 255)));
				put("*/");
			end
			14: begin
				repeat ($urandom_range(1, 3)) frag.push_back($urandom_range(1) ? 8'h0A : 8'h0D);
				if ($urandom_range(3) == 0) frag.push_back(8'h00);
			end
			15: begin
				put($urandom_range(1) ? "/ " : "+-*~[]:#!|&=<>(){}\\");
			end
			default: begin
				repeat ($urandom_range(1, 5)) frag.push_back(8'($urandom_range(255)));
			end
		endcase
	endfunction

	function void error_tail();
		case ($urandom_range(7))
			0: put("$");
			1: repeat (TOKEN_MAX + 1) put("q");
			2: put("\"\\z");
			3: begin
				put("\"ab");
				frag.push_back(8'h07);
			end
			4: begin
				put("/* open");
				frag.push_back(8'h00);
			end
			5: put("12a ");
			6: put("\"\\x1ff");
			default: put("'ABCDE'");
		endcase
		put(" after 1 \"x\"\n");
		frag.push_back(8'h00);
		commit(1);
	endfunction

	initial begin
		string directed[$];
		clk = 0;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.ch = 0;
		res.ready = 0;
		s = '{mode: LM_NORMAL, default: 0};
		gen_st = s;
		chk_st = s;
		directed = '{"\n\r\n", "label: mov r1, 0x1F\n", "; note\n", "// note\n",
			"/* x\n**/", "a / b\n", "\"\"", "''", "'ABCD'", "'\\n\\''",
			"\"a\\x41\\101\\7z\\n\"", "0ffh ", "17q ", "0101b ", "0x1b ", "017 ",
			"4294967296 ", "3.14159 ", "65535.99999 ", "70000.5 ", ".5 ",
			"~Zz_9 {}\n"};
		foreach (directed[i]) begin
			put(directed[i]);
			commit(0);
		end
		put(";");
		frag.push_back(8'hFF);
		frag.push_back(8'h80);
		frag.push_back(8'h0A);
		frag.push_back(8'h00);
		commit(0);
		while (source_bytes.size() < 290) begin
			random_frag();
			commit(0);
		end
		error_tail();
		n_pending = source_bytes.size();
		gen_done = 1;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk or negedge arst_n) begin
		bit calm;
		calm = sent > 120 && sent < 200;
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.ch <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				s = chk_st;
				lex_byte(in_ch.ch);
				chk_st = s;
				foreach (emitted[i]) expected_tokens.push_back(emitted[i]);
				n_expected = expected_tokens.size();
				sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (source_bytes.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
					in_ch.valid <= 1;
					in_ch.ch <= source_bytes.pop_front();
				end else begin
					in_ch.valid <= 0;
				end
				n_pending = source_bytes.size();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			res.ready <= 0;
		end else begin
			res.ready <= (sent > 120 && sent < 200) || $urandom_range(99) >= 29;
			if (res.valid && res.ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected transfer kind %0d value %h code %0d last %0b",
						$realtime, res.kind, res.value, res.error_code, res.last);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					n_expected = expected_tokens.size();
					if (res.kind !== want.kind || res.value !== want.value ||
							res.error_code !== want.code || res.last !== want.last) begin
						$display("%0t: expected kind %0d value %h code %0d last %0b, %s",
							$realtime, want.kind, want.value, want.code, want.last,
							$sformatf("actual kind %0d value %h code %0d last %0b",
							res.kind, res.value, res.error_code, res.last));
						fails++;
					end
				end
			end
		end
	end

	initial begin
		wait (gen_done);
		wait (n_pending == 0 && arst_n);
		@(posedge clk);
		wait (!in_ch.valid);
		wait (n_expected == 0);
		repeat (60) @(posedge clk);
		if (fails == 0 && n_expected == 0) begin
			$display("assembler_source_lexer_tb: PASS");
		end else begin
			$display("assembler_source_lexer_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("assembler_source_lexer_tb: FAIL");
		$finish;
	end
endmodule
